>>> src/pffa_pkg.sv
// shared types and constants of the page frame allocator
package pffa_pkg;

  localparam int PAGE_FRAMES = 4096;
  localparam int PAGE_W      = $clog2(PAGE_FRAMES);
  localparam int LINK_W      = PAGE_W + 1;
  localparam int MAX_BATCH   = 64;
  localparam int CNT_W       = 7;
  localparam int CFG_W       = 13;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_W        = 24;
  localparam int OUT_W       = 32;

  localparam logic [LINK_W-1:0] NIL = '1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_PAGES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_FREE  = 2'd1;

  typedef enum logic [1:0] {
    PS_BUSY   = 2'd0,
    PS_FREE   = 2'd1,
    PS_ZEROED = 2'd2
  } pstate_t;

  typedef enum logic [1:0] {
    CMD_INIT       = 2'd0,
    CMD_ALLOC_ANY  = 2'd1,
    CMD_ALLOC_ZERO = 2'd2,
    CMD_FREE       = 2'd3
  } cmd_kind_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOMEM   = 2'd1,
    STS_BADFREE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_INIT, S_POP_RD, S_POP_WR, S_FREE_RD, S_FREE_WR, S_RESP
  } fsm_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CNT_W-1:0]   count;
    logic [PAGE_W-1:0]  page;
  } cmd_t;

  typedef struct packed {
    pstate_t           st;
    logic [LINK_W-1:0] link;
  } entry_t;

  // status the back end reports to the front end
  typedef struct packed {
    logic clearing;
  } bk_status_t;

endpackage

>>> src/pffa_ram.sv
// generic single write port ram with registered read
module pffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/pffa_front.sv
// front end: accepts requests, classifies them and queues them
module pffa_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // opcode[1:0], page_count[8:2], freed_page[20:9], zero fill
  input  logic [pffa_pkg::IN_W-1:0] in_tdata,
  input  pffa_pkg::bk_status_t bk_status,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output pffa_pkg::cmd_t       cmd
);
  import pffa_pkg::*;

  cmd_t        q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r, cnt_nxt;
  cmd_t        cls;
  logic        push, pop;
  logic [CNT_W-1:0] raw_cnt;

  // classify the incoming request
  always_comb begin
    raw_cnt   = in_tdata[8:2];
    cls.kind  = cmd_kind_t'(in_tdata[1:0]);
    cls.count = (raw_cnt > CNT_W'(MAX_BATCH)) ? CNT_W'(MAX_BATCH) : raw_cnt;
    cls.page  = in_tdata[20:9];
  end

  assign in_tready = (cnt_r != 2'd2) && !bk_status.clearing;
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

>>> src/pffa_back.sv
// back end: walks the page frame table and produces results
module pffa_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [pffa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pffa_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  pffa_pkg::cmd_t       cmd,
  output pffa_pkg::bk_status_t bk_status,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [pffa_pkg::OUT_W-1:0] out_tdata,
  output logic                 out_tlast
);
  import pffa_pkg::*;

  fsm_t              state_r, state_nxt;
  logic [CFG_W-1:0]  total_r, first_r, eff_tot;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] fcount_r, fcount_nxt;
  logic [PAGE_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [LINK_W-1:0] avail_r, avail_nxt;
  logic              zmode_r, zmode_nxt;
  status_t           sts_r, sts_nxt;
  logic [PAGE_W-1:0] cur_r, cur_nxt;

  logic              out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic              emit_ok, idx_end, in_init_range;
  logic [LINK_W-1:0] idx_inc;

  logic              we;
  logic [PAGE_W-1:0] waddr, raddr;
  entry_t            wdata, rdata;

  pffa_ram #(.WIDTH($bits(entry_t)), .DEPTH(PAGE_FRAMES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign eff_tot       = (total_r > CFG_W'(PAGE_FRAMES)) ? CFG_W'(PAGE_FRAMES) : total_r;
  assign emit_ok       = !out_valid_r || out_tready;
  assign idx_end       = (idx_r == '1);
  assign idx_inc       = {1'b0, idx_r} + LINK_W'(1);
  assign in_init_range = ({1'b0, idx_r} >= first_r) && ({1'b0, idx_r} < eff_tot);
  assign cmd_ready     = (state_r == S_IDLE);
  assign bk_status.clearing = (state_r == S_CLEAR);
  assign raddr = (state_r == S_POP_RD || state_r == S_POP_WR) ? head_r[PAGE_W-1:0] : cur_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:   if (idx_end) state_nxt = S_IDLE;
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_INIT: state_nxt = S_INIT;
            CMD_FREE: state_nxt = ({1'b0, cmd.page} >= eff_tot) ? S_RESP : S_FREE_RD;
            default: begin
              if (cmd.count == '0 || LINK_W'(cmd.count) > fcount_r) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_POP_RD;
              end
            end
          endcase
        end
      end
      S_INIT:    if (idx_end) state_nxt = S_RESP;
      S_POP_RD:  state_nxt = S_POP_WR;
      S_POP_WR:  if (emit_ok) state_nxt = (rem_r == CNT_W'(1)) ? S_IDLE : S_POP_RD;
      S_FREE_RD: state_nxt = S_FREE_WR;
      S_FREE_WR: state_nxt = S_RESP;
      S_RESP:    if (emit_ok) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    head_nxt      = head_r;
    fcount_nxt    = fcount_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    avail_nxt     = avail_r;
    zmode_nxt     = zmode_r;
    sts_nxt       = sts_r;
    cur_nxt       = cur_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata.st      = PS_BUSY;
    wdata.link    = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        idx_nxt = idx_r + PAGE_W'(1);
      end
      S_IDLE: begin
        idx_nxt   = '0;
        cur_nxt   = cmd.page;
        rem_nxt   = cmd.count;
        avail_nxt = fcount_r - LINK_W'(cmd.count);
        zmode_nxt = (cmd.kind == CMD_ALLOC_ZERO);
        if (cmd.kind == CMD_FREE) begin
          sts_nxt = ({1'b0, cmd.page} >= eff_tot) ? STS_BADFREE : STS_OK;
        end else if (cmd.kind == CMD_INIT || cmd.count == '0) begin
          sts_nxt = STS_OK;
        end else begin
          sts_nxt = STS_NOMEM;
        end
      end
      S_INIT: begin
        we      = 1'b1;
        idx_nxt = idx_r + PAGE_W'(1);
        if (in_init_range) begin
          wdata.st   = PS_FREE;
          wdata.link = (idx_inc < eff_tot) ? idx_inc : NIL;
        end
        if (idx_end) begin
          if (first_r < eff_tot) begin
            head_nxt   = first_r;
            fcount_nxt = eff_tot - first_r;
          end else begin
            head_nxt   = NIL;
            fcount_nxt = '0;
          end
        end
      end
      S_POP_WR: begin
        if (emit_ok) begin
          we            = 1'b1;
          waddr         = head_r[PAGE_W-1:0];
          wdata.link    = rdata.link;
          head_nxt      = rdata.link;
          fcount_nxt    = fcount_r - LINK_W'(1);
          rem_nxt       = rem_r - CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, avail_r, STS_OK, zmode_r, 1'b1, head_r[PAGE_W-1:0]};
          out_last_nxt  = (rem_r == CNT_W'(1));
        end
      end
      S_FREE_WR: begin
        if (rdata.st == PS_BUSY) begin
          we         = 1'b1;
          waddr      = cur_r;
          wdata.st   = PS_FREE;
          wdata.link = head_r;
          head_nxt   = {1'b0, cur_r};
          fcount_nxt = fcount_r + LINK_W'(1);
        end else begin
          sts_nxt = STS_BADFREE;
        end
      end
      S_RESP: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, fcount_r, sts_r, 1'b0, 1'b0, PAGE_W'(0)};
          out_last_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      head_r      <= NIL;
      fcount_r    <= '0;
      out_valid_r <= 1'b0;
      total_r     <= CFG_W'(PAGE_FRAMES);
      first_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      head_r      <= head_nxt;
      fcount_r    <= fcount_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_addr == CFG_TOTAL_PAGES) total_r <= cfg_wdata;
      if (cfg_we && cfg_addr == CFG_FIRST_FREE)  first_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    avail_r    <= avail_nxt;
    zmode_r    <= zmode_nxt;
    sts_r      <= sts_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

>>> src/page_frame_free_list_allocator_core.sv
// top level of the page frame free list allocator
// an allocate of n pages gives its pages one at a time (table read then write), waiting while a result is not taken
// init walks the whole table, one entry write a cycle
// reset is synchronous; afterwards a clearing pass marks every frame busy
// while no request is taken; configuration writes are taken at any time
module page_frame_free_list_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[1:0], page_count[8:2], freed_page[20:9], zero fill
  input  logic [pffa_pkg::IN_W-1:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // page_number[11:0], page_valid[12], needs_zeroing[13], status[15:14],
  // available_pages[28:16], zero fill
  output logic [pffa_pkg::OUT_W-1:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [pffa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pffa_pkg::CFG_W-1:0]      cfg_wdata
);
  import pffa_pkg::*;

  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;
  bk_status_t bk_status;

  pffa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .bk_status (bk_status),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  pffa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .bk_status  (bk_status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> src/pffa_checker.sv
// port-level checks of the allocator, bound to the top level
module pffa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // a result waiting for transfer stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");

  // a result without a page always closes its request
  a_nopage_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[12] |-> out_tlast)
    else $error("pageless result not marked last");

  // error results never carry a page
  a_err_nopage: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:14] != 2'd0 |-> !out_tdata[12])
    else $error("error result carries a page");

  // zeroing flag only on granted pages
  a_nz_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> out_tdata[12])
    else $error("needs_zeroing without a page");

  // available count never exceeds the table size
  a_avail_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[28:16] <= 13'd4096)
    else $error("available pages out of range");

endmodule

bind page_frame_free_list_allocator_core pffa_checker u_pffa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
